@@ src/assert_macros.svh @@
// assertion macros used by the checker file
// expects signals named clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CHK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define CHK_NEVER(label, cond, msg) \
  `CHK_PROP(label, !(cond), msg)

`endif

@@ src/yrbo_pkg.sv @@
// shared types, constants and the blend function of the uyvy box reticle overlay
// no dependencies
package yrbo_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // geometry math width, covers 13-bit registers and frame sizes up to 8192
  localparam int GEO_W = 14;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RGB    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY      = 3'd7;

  localparam logic [8:0] OPAQUE = 9'd256;

  // bt.601 rgb to yuv in 8-bit fixed point
  localparam logic signed [18:0] K_YR = 19'sd66;
  localparam logic signed [18:0] K_YG = 19'sd129;
  localparam logic signed [18:0] K_YB = 19'sd25;
  localparam logic signed [18:0] K_UR = -19'sd38;
  localparam logic signed [18:0] K_UG = -19'sd74;
  localparam logic signed [18:0] K_UB = 19'sd112;
  localparam logic signed [18:0] K_VR = 19'sd112;
  localparam logic signed [18:0] K_VG = -19'sd94;
  localparam logic signed [18:0] K_VB = -19'sd18;
  localparam logic signed [18:0] K_ROUND = 19'sd128;
  localparam logic [7:0] Y_BIAS = 8'd16;
  localparam logic [7:0] C_OFFSET = 8'd128;

  typedef struct packed {
    logic [GEO_W-1:0] lo_x;
    logic [GEO_W-1:0] hi_x;
    logic [GEO_W-1:0] lo_y;
    logic [GEO_W-1:0] hi_y;
    logic [7:0]       luma;
    logic [7:0]       cb;
    logic [7:0]       cr;
    logic [8:0]       op;
  } ovl_params_t;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] lin;
    logic [7:0]  u;
    logic [7:0]  y0;
    logic [7:0]  v;
    logic [7:0]  y1;
  } pix_t;

  function automatic logic [7:0] blend(input logic [8:0] op, input logic [7:0] c,
                                       input logic [7:0] px);
    logic [16:0] acc;
    acc = 17'(op) * 17'(c) + 17'(OPAQUE - op) * 17'(px);
    return acc[15:8];
  endfunction

endpackage

@@ src/yrbo_cfg.sv @@
// configuration registers and the derived box bounds and yuv colour
// depends on yrbo_pkg
module yrbo_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [yrbo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yrbo_pkg::CFG_DATA_W-1:0]  cfg_data,
  output yrbo_pkg::ovl_params_t            params
);
  import yrbo_pkg::*;

  logic [11:0] center_x, center_y, half_width, half_height;
  logic [12:0] frame_width, frame_height;
  logic [23:0] color_rgb;
  logic [8:0]  opacity;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= 12'd320;
      center_y     <= 12'd240;
      half_width   <= 12'd5;
      half_height  <= 12'd5;
      frame_width  <= 13'd640;
      frame_height <= 13'd480;
      color_rgb    <= 24'h00FF00;
      opacity      <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X:     center_x     <= cfg_data[11:0];
        REG_CENTER_Y:     center_y     <= cfg_data[11:0];
        REG_HALF_WIDTH:   half_width   <= cfg_data[11:0];
        REG_HALF_HEIGHT:  half_height  <= cfg_data[11:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[12:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        REG_COLOR_RGB:    color_rgb    <= cfg_data[23:0];
        REG_OPACITY:      opacity      <= cfg_data[8:0];
      endcase
    end
  end

  // first stage: saturated frame, limited half sizes, colour sums, clamped opacity
  logic [GEO_W-1:0] fw_next, fh_next, hw_next, hh_next;
  logic [GEO_W-1:0] fw_ext, fh_ext, hwid_ext, hhgt_ext;
  logic signed [18:0] rr, gg, bb;
  logic signed [18:0] sum_y_next, sum_u_next, sum_v_next;
  logic [8:0] op_next;

  always_comb begin
    fw_ext   = GEO_W'(frame_width);
    fh_ext   = GEO_W'(frame_height);
    hwid_ext = GEO_W'(half_width);
    hhgt_ext = GEO_W'(half_height);
    if (fw_ext < GEO_W'(2))              fw_next = GEO_W'(2);
    else if (fw_ext > GEO_W'(MAX_WIDTH)) fw_next = GEO_W'(MAX_WIDTH);
    else                                 fw_next = fw_ext;
    if (fh_ext < GEO_W'(1))               fh_next = GEO_W'(1);
    else if (fh_ext > GEO_W'(MAX_HEIGHT)) fh_next = GEO_W'(MAX_HEIGHT);
    else                                  fh_next = fh_ext;
    hw_next = (hwid_ext > (fw_next >> 1)) ? (fw_next >> 1) : hwid_ext;
    hh_next = (hhgt_ext > (fh_next >> 1)) ? (fh_next >> 1) : hhgt_ext;
    rr = $signed({11'd0, color_rgb[23:16]});
    gg = $signed({11'd0, color_rgb[15:8]});
    bb = $signed({11'd0, color_rgb[7:0]});
    sum_y_next = K_YR * rr + K_YG * gg + K_YB * bb;
    sum_u_next = K_UR * rr + K_UG * gg + K_UB * bb;
    sum_v_next = K_VR * rr + K_VG * gg + K_VB * bb;
    op_next = (opacity > OPAQUE) ? OPAQUE : opacity;
  end

  logic [GEO_W-1:0] fw, fh, hw, hh;
  logic signed [18:0] sum_y, sum_u, sum_v;
  logic [8:0] op1;

  always_ff @(posedge clk) begin
    fw    <= fw_next;
    fh    <= fh_next;
    hw    <= hw_next;
    hh    <= hh_next;
    sum_y <= sum_y_next;
    sum_u <= sum_u_next;
    sum_v <= sum_v_next;
    op1   <= op_next;
  end

  // second stage: clamp centre, round down to even, finish the colour
  logic [GEO_W-1:0] cx_ext, cy_ext, cx_c, cy_c;
  logic [GEO_W-1:0] cx_even_next, hw_even_next;
  logic signed [18:0] t_y, t_u, t_v;
  logic [7:0] luma_next, cb_next, cr_next;

  always_comb begin
    cx_ext = GEO_W'(center_x);
    cy_ext = GEO_W'(center_y);
    if (cx_ext < hw)           cx_c = hw;
    else if (cx_ext > fw - hw) cx_c = fw - hw;
    else                       cx_c = cx_ext;
    if (cy_ext < hh)           cy_c = hh;
    else if (cy_ext > fh - hh) cy_c = fh - hh;
    else                       cy_c = cy_ext;
    cx_even_next = {cx_c[GEO_W-1:1], 1'b0};
    hw_even_next = {hw[GEO_W-1:1], 1'b0};
    // floor shift of the rounded sum, offset wraps into the byte
    t_y = (sum_y + K_ROUND) >>> 8;
    t_u = (sum_u + K_ROUND) >>> 8;
    t_v = (sum_v + K_ROUND) >>> 8;
    luma_next = t_y[7:0] + Y_BIAS;
    cb_next   = t_u[7:0] + C_OFFSET;
    cr_next   = t_v[7:0] + C_OFFSET;
  end

  logic [GEO_W-1:0] cx_even, hw_even, cy_cl, hh2;
  logic [7:0] luma2, cb2, cr2;
  logic [8:0] op2;

  always_ff @(posedge clk) begin
    cx_even <= cx_even_next;
    hw_even <= hw_even_next;
    cy_cl   <= cy_c;
    hh2     <= hh;
    luma2   <= luma_next;
    cb2     <= cb_next;
    cr2     <= cr_next;
    op2     <= op1;
  end

  // third stage: box edges
  always_ff @(posedge clk) begin
    params.lo_x <= cx_even - hw_even;
    params.hi_x <= cx_even + hw_even;
    params.lo_y <= cy_cl - hh2;
    params.hi_y <= cy_cl + hh2;
    params.luma <= luma2;
    params.cb   <= cb2;
    params.cr   <= cr2;
    params.op   <= op2;
  end

endmodule

@@ src/yrbo_pipe.sv @@
// pixel pair pipeline: box test and alpha blend over five register stages
// depends on yrbo_pkg; bounds come from yrbo_cfg aligned with stage three
module yrbo_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [11:0]           column,
  input  logic [11:0]           line,
  input  logic [7:0]            u_in,
  input  logic [7:0]            y0_in,
  input  logic [7:0]            v_in,
  input  logic [7:0]            y1_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            u_out,
  output logic [7:0]            y0_out,
  output logic [7:0]            v_out,
  output logic [7:0]            y1_out,
  output logic                  inside_box,
  input  yrbo_pkg::ovl_params_t params
);
  import yrbo_pkg::*;

  logic en;
  logic v1, v2, v3, v4, v5;
  pix_t s1, s2, s3, s4;
  logic in4;
  logic [GEO_W-1:0] col3, lin3;
  logic inside3;

  // whole pipeline advances together; the output register frees up when its result is taken
  assign en       = !v5 || out_ready;
  assign in_ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    col3 = GEO_W'({s3.col[11:1], 1'b0});
    lin3 = GEO_W'(s3.lin);
    inside3 = (col3 >= params.lo_x) && (col3 < params.hi_x) &&
              (lin3 >= params.lo_y) && (lin3 < params.hi_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= '{col: column, lin: line, u: u_in, y0: y0_in, v: v_in, y1: y1_in};
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
      in4 <= inside3;
      inside_box <= in4;
      u_out  <= in4 ? blend(params.op, params.cb, s4.u)    : s4.u;
      y0_out <= in4 ? blend(params.op, params.luma, s4.y0) : s4.y0;
      v_out  <= in4 ? blend(params.op, params.cr, s4.v)    : s4.v;
      y1_out <= in4 ? blend(params.op, params.luma, s4.y1) : s4.y1;
    end
  end

  assign out_valid = v5;

endmodule

@@ src/yuv422_box_reticle_overlay_unit.sv @@
// a taken request passes through registers s1, s2, s3 and s4 of yrbo_pipe into the output register
// throughput: one pixel pair per cycle; a stall at the output holds every stage
// config writes are taken every cycle; derived bounds follow through the registered stages of yrbo_cfg
// reset clears all valid bits and loads the register defaults
// top level of the uyvy box reticle overlay
// depends on yrbo_pkg, yrbo_cfg and yrbo_pipe
module yuv422_box_reticle_overlay_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [11:0]                      column,
  input  logic [11:0]                      line,
  input  logic [7:0]                       u_in,
  input  logic [7:0]                       y0_in,
  input  logic [7:0]                       v_in,
  input  logic [7:0]                       y1_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       u_out,
  output logic [7:0]                       y0_out,
  output logic [7:0]                       v_out,
  output logic [7:0]                       y1_out,
  output logic                             inside_box,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [yrbo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yrbo_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import yrbo_pkg::*;

  ovl_params_t params;

  yrbo_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .params    (params)
  );

  yrbo_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .column     (column),
    .line       (line),
    .u_in       (u_in),
    .y0_in      (y0_in),
    .v_in       (v_in),
    .y1_in      (y1_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .u_out      (u_out),
    .y0_out     (y0_out),
    .v_out      (v_out),
    .y1_out     (y1_out),
    .inside_box (inside_box),
    .params     (params)
  );

endmodule

@@ src/yrbo_checker.sv @@
// port-level checks of the overlay unit and their bind to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module yrbo_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] u_out,
  input logic [7:0] y0_out,
  input logic [7:0] v_out,
  input logic [7:0] y1_out,
  input logic       inside_box
);

  `CHK_PROP(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(u_out) && $stable(y0_out) && $stable(v_out) && $stable(y1_out) && $stable(inside_box), "stalled result changed")
  `CHK_NEVER(a_backpressure, out_valid && !out_ready && in_ready, "request taken while output stalled")
  `CHK_PROP(a_empty_ready, !out_valid |-> in_ready, "input blocked with empty output")
  `CHK_PROP(a_latency, in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid, "result missing after five cycles")

endmodule

bind yuv422_box_reticle_overlay_unit yrbo_checker u_yrbo_checker (.*);
